/* rtl/pll_pkg.sv */
package pll_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = 7;
    localparam int DataW     = 32;

    typedef enum logic [1:0] {
        REG_BEFORE = 2'd0,
        REG_INSIDE = 2'd1,
        REG_PAST   = 2'd2
    } t_region;

    // Interpolation job handed from the search to the math engine.
    typedef struct packed {
        logic [DataW-1:0] mag;   // |y1-y0|, up to 2^32-1
        logic [DataW-1:0] dx;    // q - x0, unsigned
        logic [DataW-1:0] d;     // x1 - x0, unsigned, nonzero
        logic [DataW-1:0] y0;
        logic             neg;   // dy negative
        logic             interp;
        t_region          region;
    } t_job;

endpackage

/* rtl/pll_front.sv */
module pll_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_command,
    input  logic [pll_pkg::IdxW-1:0]  i_point_index,
    input  logic [pll_pkg::DataW-1:0] i_point_x,
    input  logic [pll_pkg::DataW-1:0] i_point_y,
    input  logic [pll_pkg::DataW-1:0] i_query_x,
    input  logic [pll_pkg::CntW-1:0]  i_count,
    input  logic                      i_job_full,
    output logic                      o_busy,
    output logic                      o_job_valid,
    output pll_pkg::t_job             o_job
);
    import pll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_PREV = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    logic [DataW-1:0] r_mem_x [MaxPoints];
    logic [DataW-1:0] r_mem_y [MaxPoints];
    t_state           r_state, n_state;
    logic [CntW-1:0]  r_i, n_i;
    logic [CntW-1:0]  r_n;
    logic [DataW-1:0] r_q;
    logic [IdxW-1:0]  r_raddr, n_raddr;
    logic [DataW-1:0] r_rx, r_ry;
    logic [DataW-1:0] r_x1, r_y1;
    t_job             r_job, n_job;
    logic             r_rd_ok, n_rd_ok;
    logic [CntW-1:0]  eff_n;
    logic             hit;
    logic signed [DataW:0] dy;

    always_comb begin
        if (i_count < CntW'(2))              eff_n = CntW'(2);
        else if (i_count > CntW'(MaxPoints)) eff_n = CntW'(MaxPoints);
        else                                 eff_n = i_count;
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy && !i_command) begin
            r_mem_x[i_point_index] <= i_point_x;
            r_mem_y[i_point_index] <= i_point_y;
        end
        r_rx <= r_mem_x[r_raddr];
        r_ry <= r_mem_y[r_raddr];
    end

    assign hit = $signed(r_rx) > $signed(r_q);
    assign dy  = $signed({r_y1[DataW-1], r_y1}) - $signed({r_ry[DataW-1], r_ry});

    // search sequencer: one slot at a time; the table read is registered
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_raddr = r_raddr;
        n_job   = r_job;
        n_rd_ok = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_command) begin
                    n_state = S_SCAN;
                    n_i     = '0;
                    n_raddr = '0;
                end
            end
            S_SCAN: begin
                n_rd_ok = 1'b1;
                if (r_rd_ok) begin
                    if (hit && r_i == '0) begin
                        n_job.interp = 1'b0;
                        n_job.region = REG_BEFORE;
                        n_job.y0     = r_ry;
                        n_state      = S_PUSH;
                    end else if (hit) begin
                        n_raddr = IdxW'(r_i - CntW'(1));
                        n_state = S_PREV;
                        n_rd_ok = 1'b0;
                    end else if (r_i + CntW'(1) == r_n) begin
                        n_job.interp = 1'b0;
                        n_job.region = REG_PAST;
                        n_job.y0     = r_ry;
                        n_state      = S_PUSH;
                    end else begin
                        n_i     = r_i + CntW'(1);
                        n_raddr = IdxW'(r_i + CntW'(1));
                        n_rd_ok = 1'b0;
                    end
                end else begin
                    n_raddr = IdxW'(r_i);
                end
            end
            S_PREV: begin
                n_rd_ok = 1'b1;
                if (r_rd_ok) begin
                    n_job.interp = 1'b1;
                    n_job.region = REG_INSIDE;
                    n_job.y0     = r_ry;
                    n_job.neg    = dy[DataW];
                    n_job.mag    = dy[DataW] ? DataW'(-dy) : dy[DataW-1:0];
                    n_job.dx     = r_q - r_rx;
                    n_job.d      = r_x1 - r_rx;
                    n_state      = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_job_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // after a read settles, raddr tracks r_i; r_rd_ok marks valid read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_ok <= n_rd_ok;
        end
        r_i     <= n_i;
        r_raddr <= n_raddr;
        r_job   <= n_job;
        if (r_state == S_IDLE) begin
            r_q <= i_query_x;
            r_n <= eff_n;
        end
        if (r_state == S_SCAN) begin
            r_x1 <= r_rx;
            r_y1 <= r_ry;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH) && !i_job_full;
    assign o_job       = r_job;

endmodule

/* rtl/pll_queue.sv */
module pll_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pll_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pll_pkg::t_job o_job
);
    import pll_pkg::*;

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // two-entry ring between search and math
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];

endmodule

/* rtl/pll_back.sv */
module pll_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  pll_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_idle,
    output logic                      o_done,
    output logic [pll_pkg::DataW-1:0] o_y_value,
    output logic [1:0]                o_region
);
    import pll_pkg::*;

    localparam int PW = 2 * DataW;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MULH = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } t_bstate;

    t_bstate          r_state;
    t_job             r_job;
    logic [PW-1:0]    r_num;      // dividend shifting out, quotient shifting in
    logic [DataW:0]   r_rem;
    logic [PW-1:0]    r_prod_lo;
    logic [6:0]       r_cnt;
    logic [DataW:0]   trial;
    logic [DataW:0]   sh_rem;
    logic [DataW-1:0] quo;

    // restoring divider, one quotient bit a cycle
    assign sh_rem = {r_rem[DataW-1:0], r_num[PW-1]};
    assign trial  = sh_rem - {1'b0, r_job.d};
    assign quo    = r_num[DataW-1:0];

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_job   <= i_job;
                        r_state <= i_job.interp ? B_MULH : B_DONE;
                    end
                end
                B_MULH: begin
                    // 32x32 product, registered
                    r_prod_lo <= PW'(r_job.mag) * PW'(r_job.dx);
                    r_rem     <= '0;
                    r_cnt     <= 7'(PW);
                    r_state   <= B_DIV;
                end
                B_DIV: begin
                    if (r_cnt == 7'(PW)) begin
                        r_num <= r_prod_lo;
                        r_cnt <= r_cnt - 7'd1;
                    end else begin
                        if (!trial[DataW]) begin
                            r_rem <= trial;
                            r_num <= {r_num[PW-2:0], 1'b1};
                        end else begin
                            r_rem <= sh_rem;
                            r_num <= {r_num[PW-2:0], 1'b0};
                        end
                        if (r_cnt == 7'd0) r_state <= B_DONE;
                        else r_cnt <= r_cnt - 7'd1;
                    end
                end
                B_DONE: begin
                    o_done   <= 1'b1;
                    o_region <= r_job.region;
                    if (!r_job.interp)   o_y_value <= r_job.y0;
                    else if (r_job.neg)  o_y_value <= r_job.y0 - quo;
                    else                 o_y_value <= r_job.y0 + quo;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_pop  = (r_state == B_IDLE) && i_valid;
    assign o_idle = (r_state == B_IDLE);

endmodule

/* rtl/piecewise_linear_lookup_unit.sv */
// Channel  | Ports                                          | Handshake
// command  | i_command i_point_index i_point_x i_point_y    | i_start & !o_busy
//          | i_query_x                                      |
// result   | o_y_value o_region                             | o_done, one cycle
// config   | i_cfg_we i_cfg_data (point_count)              | i_cfg_we
// A load writes one table entry. A query searches the table slot by slot in
// the front (registered table read), then the back does the multiply and
// 64-step restoring divide; clamped answers skip both.
// A two-entry queue lets the next search overlap the previous divide.
// Reset is synchronous; table contents are not cleared.
// The result receiver cannot stall; results appear on o_done.
module piecewise_linear_lookup_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic                      i_command,
    input  logic [pll_pkg::IdxW-1:0]  i_point_index,
    input  logic [pll_pkg::DataW-1:0] i_point_x,
    input  logic [pll_pkg::DataW-1:0] i_point_y,
    input  logic [pll_pkg::DataW-1:0] i_query_x,
    input  logic                      i_cfg_we,
    input  logic [pll_pkg::CntW-1:0]  i_cfg_data,
    output logic                      o_done,
    output logic [pll_pkg::DataW-1:0] o_y_value,
    output logic [1:0]                o_region
);
    import pll_pkg::*;

    logic [CntW-1:0] r_count;
    logic            job_valid, q_full, q_valid, pop, back_idle;
    t_job            job, q_job;

    // point_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_count <= CntW'(2);
        else if (i_cfg_we) r_count <= i_cfg_data;
    end

    pll_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_command, .i_point_index, .i_point_x,
        .i_point_y, .i_query_x, .i_count(r_count), .i_job_full(q_full),
        .o_busy, .o_job_valid(job_valid), .o_job(job)
    );

    pll_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_job(job), .i_pop(pop),
        .o_full(q_full), .o_valid(q_valid), .o_job(q_job)
    );

    pll_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(q_job), .o_pop(pop),
        .o_idle(back_idle), .o_done, .o_y_value, .o_region
    );

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(!back_idle)) else $error("result without work");
    a_region_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_region != 2'd3)) else $error("bad region");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !job_valid) else $error("queue overflow");

endmodule
